/* hdl/mpvm_pkg.sv */
// ----------------------------------------------------------------------------
// mpvm_pkg
// Shared widths, register indexes, reset values and small helper functions
// for the memory pressure volatility monitor.
// ----------------------------------------------------------------------------
package mpvm_pkg;

  // Field widths
  localparam int SAMPLE_W   = 17;
  localparam int MILLI_W    = 27;   // 1000 * sample fits here
  localparam int RSSM_W     = 20;   // usage per limit in thousandths
  localparam int ALPHA_W    = 11;
  localparam int THR_W      = 13;
  localparam int LIMIT_W    = 17;
  localparam int VOL_W      = 14;
  localparam int UTIL_W     = 25;
  localparam int PCT_W      = 7;
  localparam int LAT_W      = 9;
  localparam int TAG_W      = 10;
  localparam int ENERGY_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd3;

  // Reset values and limits
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 11'd350;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 11'd2000;
  localparam logic [THR_W-1:0]   THR1_RST   = 13'd120;
  localparam logic [THR_W-1:0]   THR2_RST   = 13'd180;
  localparam logic [THR_W-1:0]   THR_MAX    = 13'd5000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 17'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN  = 17'd128;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = 17'd65536;
  localparam int                 MIN_SAMPLES = 8;
  localparam logic [VOL_W-1:0]   VOL_MAX    = 14'd12000;

  // floor(x / 100) for x below 14000, by reciprocal multiply
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [27:0] p;
    p = {14'd0, x} * 28'd5243;
    return p[26:19];
  endfunction

  // floor(x / 10) for x below 1000
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd205;
    return p[17:11];
  endfunction

  // floor(x / 20) for x up to 12000
  function automatic logic [9:0] div20(input logic [13:0] x);
    logic [29:0] p;
    p = {16'd0, x} * 30'd3277;
    return p[25:16];
  endfunction

endpackage

/* hdl/memory_pressure_volatility_monitor_top.sv */
// ----------------------------------------------------------------------------
// memory_pressure_volatility_monitor_top
// Windowed usage volatility, utilization index and enforcement proxies,
// built around one bit-serial divider, multiplier and square root unit.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   usage_sample_mb_i
// result    out        out_valid_o / out_ready_i seven result fields
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item at a time. With fewer than 8 stored samples the window pass is
// skipped; otherwise the serial divider and the shift-add squaring of each
// deviation set the processing time.
// Reset clears control and configuration state; the window needs no clearing.
// A waiting result holds in the output register; the next item is taken
// while it waits, and the final load stalls until the register is free.
// ----------------------------------------------------------------------------
module memory_pressure_volatility_monitor_top
  import mpvm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   usage_sample_mb_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VOL_W-1:0]      volatility_milli_o,
  output logic [UTIL_W-1:0]     utilization_milli_o,
  output logic [PCT_W-1:0]      enforce_level_pct_o,
  output logic [PCT_W-1:0]      rate_multiplier_pct_o,
  output logic [LAT_W-1:0]      latency_proxy_ms_o,
  output logic [TAG_W-1:0]      tagging_time_ms_o,
  output logic [ENERGY_W-1:0]   energy_proxy_mw_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SumW  = SAMPLE_W + CntW;
  localparam int AccW  = 2 * MILLI_W + CntW;
  localparam int SqW   = (AccW + 1) / 2;
  localparam int StepW = $clog2(AccW + 1);
  localparam logic [CntW-1:0] DepthLast = CntW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0] DepthFull = CntW'(WINDOW_DEPTH);
  localparam logic [CntW-1:0] MinCnt    = CntW'(MIN_SAMPLES);

  // State codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RSS     = 4'd1;
  localparam logic [3:0] S_SUM_RD  = 4'd2;
  localparam logic [3:0] S_SUM_ACC = 4'd3;
  localparam logic [3:0] S_MEAN    = 4'd4;
  localparam logic [3:0] S_VAR_RD  = 4'd5;
  localparam logic [3:0] S_VAR_LD  = 4'd6;
  localparam logic [3:0] S_VAR_MUL = 4'd7;
  localparam logic [3:0] S_VAR_DIV = 4'd8;
  localparam logic [3:0] S_SQRT    = 4'd9;
  localparam logic [3:0] S_QDIV    = 4'd10;
  localparam logic [3:0] S_UTIL_LD = 4'd11;
  localparam logic [3:0] S_UTIL    = 4'd12;
  localparam logic [3:0] S_FINAL   = 4'd13;

  logic [3:0]           state_q;
  logic [SAMPLE_W-1:0]  win_mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0]  rd_data_q;
  logic [AW-1:0]        wr_pos_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      idx_q;
  logic [SumW-1:0]      sum_q;
  logic [MILLI_W-1:0]   mean_q;
  logic [AccW-1:0]      acc_q;
  logic [AccW-1:0]      mcand_q;
  logic [MILLI_W-1:0]   mplier_q;
  logic [StepW-1:0]     step_q;
  logic [AccW-1:0]      div_num_q;
  logic [MILLI_W-1:0]   div_den_q;
  logic [MILLI_W-1:0]   div_rem_q;
  logic [2*SqW-1:0]     rad_q;
  logic [SqW-1:0]       root_q;
  logic [SqW+1:0]       srem_q;
  logic [RSSM_W-1:0]    rss_milli_q;
  logic [VOL_W-1:0]     vol_q;
  logic [UTIL_W-1:0]    util_q;
  logic [ALPHA_W-1:0]   alpha_q;
  logic [THR_W-1:0]     thr1_q;
  logic [THR_W-1:0]     thr2_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 ovalid_q;

  // Divider step: one quotient bit per cycle
  logic [MILLI_W:0]     rem_sh;
  logic                 div_ge;
  logic [MILLI_W-1:0]   div_rem_n;
  logic [AccW-1:0]      div_quo;
  logic                 div_last;

  assign rem_sh    = {div_rem_q, div_num_q[AccW-1]};
  assign div_ge    = rem_sh >= {1'b0, div_den_q};
  assign div_rem_n = div_ge ? MILLI_W'(rem_sh - {1'b0, div_den_q}) : rem_sh[MILLI_W-1:0];
  assign div_quo   = {div_num_q[AccW-2:0], div_ge};
  assign div_last  = step_q == StepW'(AccW - 1);

  // Square root step: two radicand bits per cycle
  logic [SqW+1:0]       srem_sh;
  logic [SqW+1:0]       trial;
  logic                 sq_ge;
  logic [SqW-1:0]       root_n;

  assign srem_sh = {srem_q[SqW-1:0], rad_q[2*SqW-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial;
  assign root_n  = {root_q[SqW-2:0], sq_ge};

  // Window pass helpers
  logic [SumW-1:0]      sum_n;
  logic [MILLI_W-1:0]   x_milli;
  logic [MILLI_W-1:0]   dev;
  logic [AccW-1:0]      acc_n;
  logic                 idx_last;

  assign sum_n    = sum_q + SumW'(rd_data_q);
  assign x_milli  = MILLI_W'({10'd0, rd_data_q} * 27'd1000);
  assign dev      = (x_milli >= mean_q) ? x_milli - mean_q : mean_q - x_milli;
  assign acc_n    = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign idx_last = idx_q == cnt_q - CntW'(1);

  // Result derivation from volatility, index and usage
  logic [PCT_W-1:0]     enf;
  logic [4:0]           m35;
  logic [4:0]           m45;
  logic [1:0]           t5;
  logic [ENERGY_W-1:0]  energy;
  logic [PCT_W-1:0]     frac;
  logic [PCT_W-1:0]     rate0;
  logic [PCT_W-1:0]     rate;
  logic [PCT_W-1:0]     press;
  logic [LAT_W-1:0]     lat_raw;
  logic [LAT_W-1:0]     lat;
  logic [TAG_W-1:0]     tag;

  always_comb begin
    enf    = 7'd0;
    m35    = 5'd0;
    m45    = 5'd0;
    t5     = 2'd0;
    energy = 8'd60;
    if (util_q > UTIL_W'(thr1_q)) begin
      enf    = 7'd30;
      m35    = 5'd10;
      m45    = 5'd13;
      t5     = 2'd1;
      energy = 8'd96;
      if (util_q > UTIL_W'(thr2_q)) begin
        enf    = 7'd65;
        m35    = 5'd22;
        m45    = 5'd29;
        t5     = 2'd3;
        energy = 8'd138;
      end
    end
    frac    = (vol_q >= 14'd289) ? 7'd100 : PCT_W'(div100(14'(vol_q * 14'd35)));
    rate0   = 7'd90 - PCT_W'(div100(14'({7'd0, frac} * 14'd40)));
    rate    = PCT_W'(div100(14'({7'd0, rate0} * (14'd100 - {9'd0, m35}))));
    press   = (rss_milli_q >= RSSM_W'(1000)) ? 7'd100 : div10(rss_milli_q[9:0]);
    lat_raw = 9'd80 + LAT_W'(div100(14'({7'd0, press} * 14'd140))) - {4'd0, m45};
    if (lat_raw < 9'd40) begin
      lat = 9'd40;
    end else if (lat_raw > 9'd400) begin
      lat = 9'd400;
    end else begin
      lat = lat_raw;
    end
    tag = 10'd22 - {8'd0, t5} + div20(vol_q);
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;

  // Write the window on accept, read one entry each cycle
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      win_mem[wr_pos_q] <= usage_sample_mb_i;
    end
    rd_data_q <= win_mem[idx_q[AW-1:0]];
  end

  // Configuration registers: field bits of the data, saturated into range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      thr1_q  <= THR1_RST;
      thr2_q  <= THR2_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ALPHA: begin
          alpha_q <= (cfg_data_i[ALPHA_W-1:0] > ALPHA_MAX) ? ALPHA_MAX
                                                           : cfg_data_i[ALPHA_W-1:0];
        end
        REG_THR1: begin
          thr1_q <= (cfg_data_i[THR_W-1:0] > THR_MAX) ? THR_MAX : cfg_data_i[THR_W-1:0];
        end
        REG_THR2: begin
          thr2_q <= (cfg_data_i[THR_W-1:0] > THR_MAX) ? THR_MAX : cfg_data_i[THR_W-1:0];
        end
        REG_LIMIT: begin
          if (cfg_data_i < LIMIT_MIN) begin
            limit_q <= LIMIT_MIN;
          end else if (cfg_data_i > LIMIT_MAX) begin
            limit_q <= LIMIT_MAX;
          end else begin
            limit_q <= cfg_data_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_pos_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // Drop valid once taken, unless the final load refills it
      if (ovalid_q && out_ready_i && state_q != S_FINAL) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            wr_pos_q <= (wr_pos_q == DepthLast[AW-1:0]) ? '0 : wr_pos_q + AW'(1);
            if (cnt_q != DepthFull) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            step_q  <= '0;
            state_q <= S_RSS;
          end
        end
        S_RSS: begin
          step_q <= step_q + StepW'(1);
          if (div_last) begin
            idx_q   <= '0;
            state_q <= (cnt_q < MinCnt) ? S_UTIL_LD : S_SUM_RD;
          end
        end
        S_SUM_RD: begin
          state_q <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          if (idx_last) begin
            idx_q   <= '0;
            step_q  <= '0;
            state_q <= (sum_n == '0) ? S_UTIL_LD : S_MEAN;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= S_SUM_RD;
          end
        end
        S_MEAN: begin
          step_q <= step_q + StepW'(1);
          if (div_last) begin
            state_q <= S_VAR_RD;
          end
        end
        S_VAR_RD: begin
          state_q <= S_VAR_LD;
        end
        S_VAR_LD: begin
          state_q <= S_VAR_MUL;
        end
        S_VAR_MUL: begin
          if ((mplier_q >> 1) == '0) begin
            if (idx_last) begin
              step_q  <= '0;
              state_q <= S_VAR_DIV;
            end else begin
              idx_q   <= idx_q + CntW'(1);
              state_q <= S_VAR_RD;
            end
          end
        end
        S_VAR_DIV: begin
          step_q <= step_q + StepW'(1);
          if (div_last) begin
            step_q  <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(SqW - 1)) begin
            step_q  <= '0;
            state_q <= S_QDIV;
          end
        end
        S_QDIV: begin
          step_q <= step_q + StepW'(1);
          if (div_last) begin
            state_q <= S_UTIL_LD;
          end
        end
        S_UTIL_LD: begin
          step_q  <= '0;
          state_q <= S_UTIL;
        end
        S_UTIL: begin
          step_q <= step_q + StepW'(1);
          if (div_last) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        div_num_q <= AccW'({10'd0, usage_sample_mb_i} * 27'd1000);
        div_den_q <= MILLI_W'(limit_q);
        div_rem_q <= '0;
        sum_q     <= '0;
        acc_q     <= '0;
      end
      S_RSS: begin
        div_num_q <= div_quo;
        div_rem_q <= div_rem_n;
        if (div_last) begin
          rss_milli_q <= div_quo[RSSM_W-1:0];
          vol_q       <= '0;
        end
      end
      S_SUM_ACC: begin
        sum_q     <= sum_n;
        div_num_q <= AccW'({10'd0, sum_n} * 37'd1000);
        div_den_q <= MILLI_W'(cnt_q);
        div_rem_q <= '0;
      end
      S_MEAN: begin
        div_num_q <= div_quo;
        div_rem_q <= div_rem_n;
        if (div_last) begin
          mean_q <= div_quo[MILLI_W-1:0];
        end
      end
      S_VAR_LD: begin
        mcand_q  <= AccW'(dev);
        mplier_q <= dev;
      end
      S_VAR_MUL: begin
        acc_q     <= acc_n;
        mcand_q   <= mcand_q << 1;
        mplier_q  <= mplier_q >> 1;
        div_num_q <= acc_n;
        div_den_q <= MILLI_W'(cnt_q);
        div_rem_q <= '0;
      end
      S_VAR_DIV: begin
        div_num_q <= div_quo;
        div_rem_q <= div_rem_n;
        rad_q     <= (2*SqW)'(div_quo);
        root_q    <= '0;
        srem_q    <= '0;
      end
      S_SQRT: begin
        rad_q     <= rad_q << 2;
        root_q    <= root_n;
        srem_q    <= sq_ge ? srem_sh - trial : srem_sh;
        div_num_q <= AccW'({10'd0, root_n} * (SqW + 10)'(1000));
        div_den_q <= mean_q;
        div_rem_q <= '0;
      end
      S_QDIV: begin
        div_num_q <= div_quo;
        div_rem_q <= div_rem_n;
        if (div_last) begin
          vol_q <= (div_quo > AccW'(VOL_MAX)) ? VOL_MAX : div_quo[VOL_W-1:0];
        end
      end
      S_UTIL_LD: begin
        div_num_q <= AccW'({14'd0, alpha_q} * {11'd0, vol_q});
        div_den_q <= MILLI_W'(1000);
        div_rem_q <= '0;
      end
      S_UTIL: begin
        div_num_q <= div_quo;
        div_rem_q <= div_rem_n;
        if (div_last) begin
          util_q <= UTIL_W'(rss_milli_q) + UTIL_W'(div_quo[14:0]);
        end
      end
      S_FINAL: begin
        if (!ovalid_q || out_ready_i) begin
          volatility_milli_o    <= vol_q;
          utilization_milli_o   <= util_q;
          enforce_level_pct_o   <= enf;
          rate_multiplier_pct_o <= rate;
          latency_proxy_ms_o    <= lat;
          tagging_time_ms_o     <= tag;
          energy_proxy_mw_o     <= energy;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Memory pressure volatility monitor testbench
// Drives usage samples and register writes with random idle and stall bursts.
// Each result is checked field by field against an in-bench predictor of the
// window volatility, utilization index and proxies, or a fixed report.
// ----------------------------------------------------------------------------
module testbench;
  import mpvm_pkg::*;

  localparam int DEPTH       = 128;
  localparam int HANG_LIMIT  = 20000;
  localparam int RAND_ITEMS  = 500;
  localparam int CALM_ITEMS  = 60;
  localparam int PHASES      = 5;

  typedef struct packed {
    logic [VOL_W-1:0]    vol;
    logic [UTIL_W-1:0]   util;
    logic [PCT_W-1:0]    enf;
    logic [PCT_W-1:0]    rate;
    logic [LAT_W-1:0]    lat;
    logic [TAG_W-1:0]    tag;
    logic [ENERGY_W-1:0] energy;
  } report_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    bit                    typed;
    report_t               exp;
  } step_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   usage_sample_mb_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [VOL_W-1:0]      volatility_milli_o;
  logic [UTIL_W-1:0]     utilization_milli_o;
  logic [PCT_W-1:0]      enforce_level_pct_o;
  logic [PCT_W-1:0]      rate_multiplier_pct_o;
  logic [LAT_W-1:0]      latency_proxy_ms_o;
  logic [TAG_W-1:0]      tagging_time_ms_o;
  logic [ENERGY_W-1:0]   energy_proxy_mw_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor state
  logic [SAMPLE_W-1:0] usage_history [DEPTH];
  int unsigned         history_wr;
  int unsigned         history_fill;
  int unsigned         vol_weight_milli;
  int unsigned         thr_low_milli;
  int unsigned         thr_high_milli;
  int unsigned         cap_mb;

  report_t     expected_reports[$];
  int          mismatches = 0;
  int          hang_cycles = 0;
  bit          calm;
  int unsigned stall_left = 0;

  memory_pressure_volatility_monitor_top #(.WINDOW_DEPTH(DEPTH)) uut (.*);

  // 20-unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Integer square root, rounded down, by bit-by-bit refinement of the root
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic int unsigned window_spread_milli();
    longint unsigned total, mean_m, acc, x, d, q;
    total = 0;
    acc = 0;
    if (history_fill < MIN_SAMPLES) return 0;
    for (int i = 0; i < history_fill; i++) total += usage_history[i];
    if (total == 0) return 0;
    mean_m = (64'd1000 * total) / history_fill;
    for (int i = 0; i < history_fill; i++) begin
      x = 64'd1000 * usage_history[i];
      d = (x >= mean_m) ? x - mean_m : mean_m - x;
      acc += d * d;
    end
    q = (64'd1000 * isqrt(acc / history_fill)) / mean_m;
    return (q > VOL_MAX) ? VOL_MAX : 32'(q);
  endfunction

  // Push one sample into the window and derive the report it produces
  function automatic report_t predict_report(logic [SAMPLE_W-1:0] rss);
    report_t     r;
    int unsigned rss_milli, vol, util, enf, frac, rate, press, lat;
    rss_milli = 32'((longint'(rss) * 1000) / cap_mb);
    usage_history[history_wr] = rss;
    history_wr = (history_wr + 1) % DEPTH;
    if (history_fill < DEPTH) history_fill++;
    vol = window_spread_milli();
    util = rss_milli + (vol_weight_milli * vol) / 1000;
    enf = 0;
    if (util > thr_low_milli) enf = (util > thr_high_milli) ? 65 : 30;
    frac = (vol * 35 / 100 > 100) ? 100 : vol * 35 / 100;
    rate = 90 - (40 * frac) / 100;
    rate = (rate * (100 - (35 * enf) / 100)) / 100;
    press = clamp_u(rss_milli / 10, 0, 100);
    lat = clamp_u(80 + (140 * press) / 100 - (45 * enf) / 100, 40, 400);
    r.vol = VOL_W'(vol);
    r.util = UTIL_W'(util);
    r.enf = PCT_W'(enf);
    r.rate = PCT_W'(rate);
    r.lat = LAT_W'(lat);
    r.tag = TAG_W'(22 - 5 * enf / 100 + vol / 20);
    r.energy = ENERGY_W'(60 + 120 * enf / 100);
    return r;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ALPHA: vol_weight_milli = clamp_u(val[ALPHA_W-1:0], 0, ALPHA_MAX);
      REG_THR1:  thr_low_milli = clamp_u(val[THR_W-1:0], 0, THR_MAX);
      REG_THR2:  thr_high_milli = clamp_u(val[THR_W-1:0], 0, THR_MAX);
      REG_LIMIT: cap_mb = clamp_u(val, LIMIT_MIN, LIMIT_MAX);
      default: ;
    endcase
  endfunction

  // Now and then, unless calm, lower valid and hold off for a random burst
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] v, bit typed, report_t typed_exp);
    report_t pred;
    in_valid_i <= 1'b1;
    usage_sample_mb_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_report(v);
    expected_reports.push_back(typed ? typed_exp : pred);
    maybe_idle();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write one register, then drop valid and leave the channel idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_write(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int unsigned hi, int unsigned lo);
    case ($urandom_range(0, 5))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      2: return {CFG_DATA_W{1'b1}};
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      mismatches++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp, act);
    end
  endtask

  // Result side: compare with the oldest expectation; random stall bursts
  always @(posedge clk_i) begin
    report_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result, expected none actual vol %0d", $time,
                 volatility_milli_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("volatility_milli", want.vol, volatility_milli_o);
        check_field("utilization_milli", want.util, utilization_milli_o);
        check_field("enforce_level_pct", want.enf, enforce_level_pct_o);
        check_field("rate_multiplier_pct", want.rate, rate_multiplier_pct_o);
        check_field("latency_proxy_ms", want.lat, latency_proxy_ms_o);
        check_field("tagging_time_ms", want.tag, tagging_time_ms_o);
        check_field("energy_proxy_mw", want.energy, energy_proxy_mw_o);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("memory_pressure_volatility_monitor_top: mismatch");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    step_row_t       rows[$];
    report_t         quiet;
    report_t         none;
    int unsigned     base, spread, v;
    logic [SAMPLE_W-1:0] s;

    calm = 1'b0;
    history_wr = 0;
    history_fill = 0;
    vol_weight_milli = ALPHA_RST;
    thr_low_milli = THR1_RST;
    thr_high_milli = THR2_RST;
    cap_mb = LIMIT_RST;
    none = '0;
    quiet = '{vol: 0, util: 0, enf: 0, rate: 90, lat: 80, tag: 22, energy: 60};

    // Directed rows: zero window (short, minimum), extremes, threshold edges
    for (int i = 0; i < 8; i++)
      rows.push_back('{0, REG_ALPHA, 17'd0, (i == 0 || i == 7), quiet});
    rows.push_back('{0, REG_ALPHA, 17'd131071, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd1, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd65535, 0, none});
    rows.push_back('{1, REG_ALPHA, 17'd0, 0, none});
    rows.push_back('{1, REG_LIMIT, 17'd1000, 0, none});
    rows.push_back('{1, REG_THR1, 17'd500, 0, none});
    rows.push_back('{1, REG_THR2, 17'd700, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd500, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd501, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd700, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd701, 0, none});
    rows.push_back('{1, REG_ALPHA, 17'd2047, 0, none});
    rows.push_back('{1, REG_THR1, 17'd0, 0, none});
    rows.push_back('{1, REG_THR2, 17'd8191, 0, none});
    rows.push_back('{1, REG_LIMIT, 17'd0, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd131071, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd0, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd128, 0, none});
    rows.push_back('{1, REG_LIMIT, 17'd131071, 0, none});
    rows.push_back('{1, REG_THR2, 17'd0, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd65536, 0, none});
    rows.push_back('{0, REG_ALPHA, 17'd1, 0, none});

    // Hold reset, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; register writes only once drained
    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        if (i == 0 || !rows[i-1].is_write) wait_drained();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_sample(rows[i].val, rows[i].typed, rows[i].exp);
      end
    end

    // Random phases: fresh registers, then samples around a base level
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_ALPHA, pick_reg_value(ALPHA_MAX, 0));
      write_reg(REG_THR1, pick_reg_value(THR_MAX, 0));
      write_reg(REG_THR2, pick_reg_value(THR_MAX, 0));
      write_reg(REG_LIMIT, pick_reg_value(LIMIT_MAX, LIMIT_MIN));
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        if (p == PHASES - 1 && k >= RAND_ITEMS / PHASES - CALM_ITEMS) calm = 1'b1;
        if (k % 40 == 0) begin
          base = $urandom_range(0, 2 * cap_mb);
          case ($urandom_range(0, 2))
            0: spread = 0;
            1: spread = base / 20 + 1;
            default: spread = base + 1;
          endcase
        end
        // Hold off once until every outstanding result is back
        if (p == 1 && k == 10) wait_drained();
        case ($urandom_range(0, 9))
          0: s = SAMPLE_W'($urandom_range(0, 131071));
          1: s = $urandom_range(0, 1) ? 17'd131071 : 17'd0;
          default: begin
            v = base + $urandom_range(0, 2 * spread);
            v = (v > spread) ? v - spread : 0;
            s = SAMPLE_W'(clamp_u(v, 0, 131071));
          end
        endcase
        send_sample(s, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("memory_pressure_volatility_monitor_top: match");
    end else begin
      $display("memory_pressure_volatility_monitor_top: mismatch");
    end
    $finish;
  end

endmodule
